@@ sv/pid_controller_step_unit_macros.svh @@
// assertion macros shared by the pid controller step unit
`ifndef PID_CONTROLLER_STEP_UNIT_MACROS_SVH
`define PID_CONTROLLER_STEP_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PIDC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PIDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/pidc_pkg.sv @@
// shared types and constants of the pid controller step unit
package pidc_pkg;

    localparam int DATA_W    = 32;
    localparam int PERIOD_W  = 20;
    localparam int LIMIT_W   = 31;
    localparam int CFG_IDX_W = 3;

    localparam logic [PERIOD_W-1:0] DT_MIN_US = 20'd100;
    localparam logic [PERIOD_W-1:0] DT_MAX_US = 20'd1000000;
    localparam logic [PERIOD_W-1:0] US_PER_S  = 20'd1000000;

    localparam int MAG_W     = 48;
    localparam int UMUL_A_W  = 33;
    localparam int UMUL_P_W  = UMUL_A_W + PERIOD_W;
    localparam int LO_W      = 24;
    localparam int DIV_W     = 68;
    localparam int DIVR_W    = 21;
    localparam int DIV_STEP  = 4;
    localparam int DIV_ITER  = DIV_W / DIV_STEP;
    localparam int DIV_CNT_W = 5;

    typedef enum logic [1:0] {
        SRC_OFF,
        SRC_ERROR,
        SRC_MEAS,
        SRC_EXT
    } deriv_src_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_GAIN_FF,
        REG_DERIV_SOURCE,
        REG_FILTER_TAU,
        REG_INTEGRAL_LIMIT,
        REG_OUTPUT_LIMIT
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIFF,
        ST_RDIV_GO,
        ST_RDIV,
        ST_FDELTA,
        ST_FDIV_GO,
        ST_FDIV,
        ST_MUL_D,
        ST_MUL_P,
        ST_MUL_FF,
        ST_MUL_I,
        ST_PDF,
        ST_IQ_LO,
        ST_IQ_HI,
        ST_IDIV_GO,
        ST_IDIV,
        ST_WIND,
        ST_DONE
    } ctl_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ERR,
        OP_DIFF,
        OP_RDIV_GO,
        OP_RAW,
        OP_FDELTA,
        OP_FDIV_GO,
        OP_FILT,
        OP_MUL_D,
        OP_MUL_P,
        OP_MUL_FF,
        OP_MUL_I,
        OP_PDF,
        OP_IQ_LO,
        OP_IQ_HI,
        OP_IDIV_GO,
        OP_CAND,
        OP_WIND,
        OP_DONE
    } dp_op_t;

    typedef enum logic [1:0] {
        DIVS_DT,
        DIVS_DT_TAU,
        DIVS_MEGA
    } div_sel_t;

    typedef struct packed {
        dp_op_t   op;
        logic     div_go;
        div_sel_t div_sel;
        logic     in_ready;
    } dp_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic sample_ok;
        logic use_rdiv;
        logic use_filter;
        logic use_integ;
        logic div_done;
        logic out_busy;
    } dp_stat_t;

endpackage

@@ sv/pidc_tick_if.sv @@
// input item channel of the pid controller step unit
interface pidc_tick_if
    import pidc_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [DATA_W-1:0]   setpoint;
    logic signed [DATA_W-1:0]   measurement;
    logic        [PERIOD_W-1:0] period_us;
    logic signed [DATA_W-1:0]   ff_value;
    logic signed [DATA_W-1:0]   ext_rate;
    logic                       ext_rate_valid;
    logic                       sample_valid;
    logic                       clear_integral;
    logic                       restart_derivative;
    logic                       allow_integrate;

    modport source (
        output valid, setpoint, measurement, period_us, ff_value, ext_rate,
               ext_rate_valid, sample_valid, clear_integral, restart_derivative,
               allow_integrate,
        input  ready
    );

    modport sink (
        input  valid, setpoint, measurement, period_us, ff_value, ext_rate,
               ext_rate_valid, sample_valid, clear_integral, restart_derivative,
               allow_integrate,
        output ready
    );
endinterface

@@ sv/pidc_result_if.sv @@
// result item channel of the pid controller step unit
interface pidc_result_if
    import pidc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive;
    logic signed [DATA_W-1:0] raw_drive;
    logic signed [DATA_W-1:0] error_value;
    logic signed [DATA_W-1:0] p_term;
    logic signed [DATA_W-1:0] i_term;
    logic signed [DATA_W-1:0] d_term;
    logic signed [DATA_W-1:0] ff_term;
    logic signed [DATA_W-1:0] d_unfiltered;
    logic                     hit_low;
    logic                     hit_high;

    modport source (
        output valid, drive, raw_drive, error_value, p_term, i_term, d_term, ff_term,
               d_unfiltered, hit_low, hit_high,
        input  ready
    );

    modport sink (
        input  valid, drive, raw_drive, error_value, p_term, i_term, d_term, ff_term,
               d_unfiltered, hit_low, hit_high,
        output ready
    );
endinterface

@@ sv/pid_controller_step_unit.sv @@
// top level of the pid controller step unit
// One control tick per item, one item at a time. When the derivative rate, the
// derivative filter and the integral step each need a division, these run one after
// another on a single shared divider that retires four quotient bits per cycle. While
// a result is stalled, the next tick waits in its final state until the output register
// is free. A new item is taken while the previous result still waits in the output
// register. Configuration is to be written through wr_en, wr_index and wr_data while
// no item is in progress; the block does not enforce this. A write to integral_limit
// also clamps the integrator to the new bound.
module pid_controller_step_unit
    import pidc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    pidc_tick_if.sink            tick,
    pidc_result_if.source        result,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [DATA_W-1:0]    wr_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pidc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    pidc_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

@@ sv/pidc_div.sv @@
// shared unsigned divider, four quotient bits per cycle
module pidc_div
    import pidc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DIVR_W-1:0] divisor,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    localparam logic [DIV_CNT_W-1:0] ITER_CNT = DIV_CNT_W'(DIV_ITER);

    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     quo_next;
    logic [DIVR_W-1:0]    rem_reg;
    logic [DIVR_W-1:0]    rem_next;
    logic [DIVR_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    always_comb
    begin
        logic [DIVR_W:0] trial;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            trial    = {rem_next, quo_next[DIV_W-1]};
            quo_next = {quo_next[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial       = trial - {1'b0, dvs_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[DIVR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= ITER_CNT;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ sv/pidc_datapath.sv @@
// datapath: registers, shared multipliers, divider and output register
module pidc_datapath
    import pidc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    pidc_tick_if.sink            tick,
    pidc_result_if.source        result,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [DATA_W-1:0]    wr_data,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat
);

    function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [68:0] v);
        if (v > 69'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -69'sd2147483648)
            return 32'sh80000000;
        return v[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] clampsym(input logic signed [49:0] v,
                                                          input logic [LIMIT_W-1:0] lim);
        logic signed [49:0] pos;
        logic signed [49:0] neg;
        pos = $signed({19'b0, lim});
        neg = -pos;
        if (v > pos)
            return pos[DATA_W-1:0];
        if (v < neg)
            return neg[DATA_W-1:0];
        return v[DATA_W-1:0];
    endfunction

    // configuration
    logic signed [DATA_W-1:0]  gain_p_reg, gain_i_reg, gain_d_reg, gain_ff_reg;
    deriv_src_t                src_reg;
    logic        [PERIOD_W-1:0] tau_reg;
    logic        [LIMIT_W-1:0]  ilim_reg, olim_reg;

    // controller state
    logic signed [DATA_W-1:0]  iacc_reg, prev_err_reg, prev_meas_reg, held_reg, filt_reg;
    logic                      primed_reg;
    logic                      out_valid_reg;

    // item and work registers
    logic signed [DATA_W-1:0]  sp_reg, meas_reg, ffv_reg, ext_reg;
    logic        [PERIOD_W-1:0] dt_reg;
    logic                      ext_ok_reg, valid_reg, clr_reg, restart_reg, integ_reg;
    logic signed [DATA_W-1:0]  err_reg, raw_reg, p_reg, d_reg, ff_reg, cand_reg;
    logic                      rst_reg, neg_reg;
    logic        [MAG_W-1:0]   mag_reg;
    logic signed [63:0]        prod_reg;
    logic        [DIV_W-1:0]   umul_reg;
    logic signed [33:0]        pdf_reg;

    // result register
    logic signed [DATA_W-1:0]  drive_reg, raw_drive_reg, err_out_reg, p_out_reg, i_out_reg;
    logic signed [DATA_W-1:0]  d_out_reg, ff_out_reg, dunf_out_reg;
    logic                      lo_reg, hi_reg;

    logic        [PERIOD_W-1:0] dt_in;
    logic signed [32:0]        err_full, diff_c, diff_abs, ext_neg, delta_c, delta_abs;
    logic signed [DATA_W-1:0]  mul_a, mul_b;
    logic signed [63:0]        prod_c;
    logic signed [47:0]        shr_c, shr_abs;
    logic signed [DATA_W-1:0]  shr_sat;
    logic        [UMUL_A_W-1:0] ua;
    logic        [PERIOD_W-1:0] ub;
    logic        [UMUL_P_W-1:0] uprod;
    logic        [DIV_W-1:0]   div_dividend;
    logic        [DIVR_W-1:0]  div_divisor;
    logic                      div_done;
    logic        [DIV_W-1:0]   quo;
    logic signed [68:0]        quo_s;
    logic signed [33:0]        fq, fnew;
    logic signed [48:0]        iq;
    logic signed [49:0]        isum;
    logic signed [34:0]        cout, sum_c, olim_pos, olim_neg;
    logic                      stop_c;
    logic signed [DATA_W-1:0]  drive_c;
    logic                      lo_c, hi_c;
    logic                      cfg_ilim_wr;

    assign dt_in = tick.period_us;

    assign err_full  = 33'(sp_reg) - 33'(meas_reg);
    assign diff_c    = (src_reg == SRC_ERROR) ? 33'(err_reg) - 33'(prev_err_reg)
                                              : 33'(prev_meas_reg) - 33'(meas_reg);
    assign diff_abs  = diff_c[32] ? -diff_c : diff_c;
    assign ext_neg   = -33'(ext_reg);
    assign delta_c   = 33'(raw_reg) - 33'(filt_reg);
    assign delta_abs = delta_c[32] ? -delta_c : delta_c;

    always_comb
    begin
        mul_a = gain_d_reg;
        mul_b = filt_reg;
        ua    = mag_reg[UMUL_A_W-1:0];
        ub    = dt_reg;
        case (cmd.op)
            OP_MUL_P:
            begin
                mul_a = gain_p_reg;
                mul_b = err_reg;
            end
            OP_MUL_FF:
            begin
                mul_a = gain_ff_reg;
                mul_b = ffv_reg;
            end
            OP_MUL_I:
            begin
                mul_a = gain_i_reg;
                mul_b = err_reg;
            end
            OP_RDIV_GO:
            begin
                ub = US_PER_S;
            end
            OP_IQ_LO:
            begin
                ua = UMUL_A_W'(mag_reg[LO_W-1:0]);
            end
            OP_IQ_HI:
            begin
                ua = UMUL_A_W'(mag_reg[MAG_W-1:LO_W]);
            end
            default:
            begin
            end
        endcase
    end

    assign prod_c  = mul_a * mul_b;
    assign shr_c   = $signed(prod_reg[63:16]);
    assign shr_abs = shr_c[47] ? -shr_c : shr_c;
    assign shr_sat = sat_wide(69'(shr_c));
    assign uprod   = UMUL_P_W'(ua) * UMUL_P_W'(ub);

    assign div_dividend = (cmd.op == OP_IDIV_GO) ? umul_reg : DIV_W'(uprod);

    always_comb
    begin
        unique case (cmd.div_sel)
            DIVS_DT:     div_divisor = DIVR_W'(dt_reg);
            DIVS_DT_TAU: div_divisor = DIVR_W'(dt_reg) + DIVR_W'(tau_reg);
            DIVS_MEGA:   div_divisor = DIVR_W'(US_PER_S);
            default:     div_divisor = DIVR_W'(US_PER_S);
        endcase
    end

    pidc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quo)
    );

    assign quo_s = neg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    assign fq    = $signed({1'b0, quo[32:0]});
    assign fnew  = 34'(filt_reg) + (neg_reg ? -fq : fq);
    assign iq    = $signed({1'b0, quo[MAG_W-1:0]});
    assign isum  = 50'(iacc_reg) + 50'(neg_reg ? -iq : iq);

    assign olim_pos = $signed({4'b0, olim_reg});
    assign olim_neg = -olim_pos;
    assign cout     = 35'(pdf_reg) + 35'(cand_reg);
    assign stop_c   = ((cout > olim_pos) && (err_reg > 0)) || ((cout < olim_neg) && (err_reg < 0));
    assign sum_c    = 35'(pdf_reg) + 35'(iacc_reg);

    always_comb
    begin
        lo_c    = 1'b0;
        hi_c    = 1'b0;
        drive_c = sum_c[DATA_W-1:0];
        if (sum_c < olim_neg)
        begin
            drive_c = olim_neg[DATA_W-1:0];
            lo_c    = 1'b1;
        end
        else if (sum_c > olim_pos)
        begin
            drive_c = olim_pos[DATA_W-1:0];
            hi_c    = 1'b1;
        end
    end

    assign cfg_ilim_wr = wr_en && (cfg_reg_t'(wr_index) == REG_INTEGRAL_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            gain_ff_reg   <= '0;
            src_reg       <= SRC_OFF;
            tau_reg       <= '0;
            ilim_reg      <= '1;
            olim_reg      <= '1;
            iacc_reg      <= '0;
            prev_err_reg  <= '0;
            prev_meas_reg <= '0;
            held_reg      <= '0;
            filt_reg      <= '0;
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (cfg_reg_t'(wr_index))
                    REG_GAIN_P:         gain_p_reg  <= wr_data;
                    REG_GAIN_I:         gain_i_reg  <= wr_data;
                    REG_GAIN_D:         gain_d_reg  <= wr_data;
                    REG_GAIN_FF:        gain_ff_reg <= wr_data;
                    REG_DERIV_SOURCE:   src_reg     <= deriv_src_t'(wr_data[1:0]);
                    REG_FILTER_TAU:     tau_reg     <= wr_data[PERIOD_W-1:0];
                    REG_INTEGRAL_LIMIT: ilim_reg    <= wr_data[LIMIT_W-1:0];
                    REG_OUTPUT_LIMIT:   olim_reg    <= wr_data[LIMIT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (cfg_ilim_wr)
                iacc_reg <= clampsym(50'(iacc_reg), wr_data[LIMIT_W-1:0]);
            else if (cmd.op == OP_ERR && valid_reg && clr_reg)
                iacc_reg <= '0;
            else if (cmd.op == OP_WIND && !stop_c)
                iacc_reg <= cand_reg;

            if (cmd.op == OP_FDELTA && !stat.use_filter)
                filt_reg <= raw_reg;
            else if (cmd.op == OP_FILT)
                filt_reg <= fnew[DATA_W-1:0];

            if (cmd.op == OP_DONE && valid_reg)
            begin
                prev_err_reg  <= err_reg;
                prev_meas_reg <= meas_reg;
                held_reg      <= drive_c;
                primed_reg    <= 1'b1;
            end

            if (cmd.op == OP_DONE)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                sp_reg      <= tick.setpoint;
                meas_reg    <= tick.measurement;
                ffv_reg     <= tick.ff_value;
                ext_reg     <= tick.ext_rate;
                ext_ok_reg  <= tick.ext_rate_valid;
                valid_reg   <= tick.sample_valid;
                clr_reg     <= tick.clear_integral;
                restart_reg <= tick.restart_derivative;
                integ_reg   <= tick.allow_integrate;
                if (dt_in < DT_MIN_US)
                    dt_reg <= DT_MIN_US;
                else if (dt_in > DT_MAX_US)
                    dt_reg <= DT_MAX_US;
                else
                    dt_reg <= dt_in;
            end
            OP_ERR:
            begin
                err_reg <= sat_wide(69'(err_full));
                rst_reg <= restart_reg || !primed_reg;
            end
            OP_DIFF:
            begin
                if (!rst_reg && src_reg == SRC_EXT && ext_ok_reg)
                    raw_reg <= sat_wide(69'(ext_neg));
                else
                    raw_reg <= '0;
                neg_reg <= diff_c[32];
                mag_reg <= MAG_W'(diff_abs);
            end
            OP_RAW:
            begin
                raw_reg <= sat_wide(quo_s);
            end
            OP_FDELTA:
            begin
                neg_reg <= delta_c[32];
                mag_reg <= MAG_W'(delta_abs);
            end
            OP_MUL_D:
            begin
                prod_reg <= prod_c;
            end
            OP_MUL_P:
            begin
                d_reg    <= shr_sat;
                prod_reg <= prod_c;
            end
            OP_MUL_FF:
            begin
                p_reg    <= shr_sat;
                prod_reg <= prod_c;
            end
            OP_MUL_I:
            begin
                ff_reg   <= shr_sat;
                prod_reg <= prod_c;
            end
            OP_PDF:
            begin
                pdf_reg <= 34'(p_reg) + 34'(d_reg) + 34'(ff_reg);
                neg_reg <= shr_c[47];
                mag_reg <= shr_abs;
            end
            OP_IQ_LO:
            begin
                umul_reg <= DIV_W'(uprod);
            end
            OP_IQ_HI:
            begin
                umul_reg <= umul_reg + (DIV_W'(uprod) << LO_W);
            end
            OP_CAND:
            begin
                cand_reg <= clampsym(isum, ilim_reg);
            end
            OP_DONE:
            begin
                if (valid_reg)
                begin
                    drive_reg     <= drive_c;
                    raw_drive_reg <= sat_wide(69'(sum_c));
                    err_out_reg   <= err_reg;
                    p_out_reg     <= p_reg;
                    i_out_reg     <= iacc_reg;
                    d_out_reg     <= d_reg;
                    ff_out_reg    <= ff_reg;
                    dunf_out_reg  <= raw_reg;
                    lo_reg        <= lo_c;
                    hi_reg        <= hi_c;
                end
                else
                begin
                    drive_reg     <= held_reg;
                    raw_drive_reg <= held_reg;
                    err_out_reg   <= '0;
                    p_out_reg     <= '0;
                    i_out_reg     <= '0;
                    d_out_reg     <= '0;
                    ff_out_reg    <= '0;
                    dunf_out_reg  <= '0;
                    lo_reg        <= 1'b0;
                    hi_reg        <= 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign stat.in_valid   = tick.valid;
    assign stat.sample_ok  = valid_reg;
    assign stat.use_rdiv   = !rst_reg && ((src_reg == SRC_ERROR) || (src_reg == SRC_MEAS) ||
                                          (src_reg == SRC_EXT && !ext_ok_reg));
    assign stat.use_filter = !rst_reg && (tau_reg != '0);
    assign stat.use_integ  = integ_reg && (gain_i_reg != '0);
    assign stat.div_done   = div_done;
    assign stat.out_busy   = out_valid_reg && !result.ready;

    assign tick.ready          = cmd.in_ready;
    assign result.valid        = out_valid_reg;
    assign result.drive        = drive_reg;
    assign result.raw_drive    = raw_drive_reg;
    assign result.error_value  = err_out_reg;
    assign result.p_term       = p_out_reg;
    assign result.i_term       = i_out_reg;
    assign result.d_term       = d_out_reg;
    assign result.ff_term      = ff_out_reg;
    assign result.d_unfiltered = dunf_out_reg;
    assign result.hit_low      = lo_reg;
    assign result.hit_high     = hi_reg;

endmodule

@@ sv/pidc_ctrl.sv @@
// controller state machine sequencing one control tick
`include "pid_controller_step_unit_macros.svh"

module pidc_ctrl
    import pidc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.div_go   = 1'b0;
        cmd.div_sel  = DIVS_DT;
        cmd.in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                cmd.op     = OP_ERR;
                state_next = stat.sample_ok ? ST_DIFF : ST_DONE;
            end
            ST_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = stat.use_rdiv ? ST_RDIV_GO : ST_FDELTA;
            end
            ST_RDIV_GO:
            begin
                cmd.op      = OP_RDIV_GO;
                cmd.div_go  = 1'b1;
                cmd.div_sel = DIVS_DT;
                state_next  = ST_RDIV;
            end
            ST_RDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_RAW;
                    state_next = ST_FDELTA;
                end
            end
            ST_FDELTA:
            begin
                cmd.op     = OP_FDELTA;
                state_next = stat.use_filter ? ST_FDIV_GO : ST_MUL_D;
            end
            ST_FDIV_GO:
            begin
                cmd.op      = OP_FDIV_GO;
                cmd.div_go  = 1'b1;
                cmd.div_sel = DIVS_DT_TAU;
                state_next  = ST_FDIV;
            end
            ST_FDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_FILT;
                    state_next = ST_MUL_D;
                end
            end
            ST_MUL_D:
            begin
                cmd.op     = OP_MUL_D;
                state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                cmd.op     = OP_MUL_P;
                state_next = ST_MUL_FF;
            end
            ST_MUL_FF:
            begin
                cmd.op     = OP_MUL_FF;
                state_next = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                cmd.op     = OP_MUL_I;
                state_next = ST_PDF;
            end
            ST_PDF:
            begin
                cmd.op     = OP_PDF;
                state_next = stat.use_integ ? ST_IQ_LO : ST_DONE;
            end
            ST_IQ_LO:
            begin
                cmd.op     = OP_IQ_LO;
                state_next = ST_IQ_HI;
            end
            ST_IQ_HI:
            begin
                cmd.op     = OP_IQ_HI;
                state_next = ST_IDIV_GO;
            end
            ST_IDIV_GO:
            begin
                cmd.op      = OP_IDIV_GO;
                cmd.div_go  = 1'b1;
                cmd.div_sel = DIVS_MEGA;
                state_next  = ST_IDIV;
            end
            ST_IDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_CAND;
                    state_next = ST_WIND;
                end
            end
            ST_WIND:
            begin
                cmd.op     = OP_WIND;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op     = OP_DONE;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `PIDC_ASSERT_NEXT(a_div_wait, (state_reg == ST_RDIV || state_reg == ST_FDIV || state_reg == ST_IDIV) && !stat.div_done, $stable(state_reg), "divide wait left early")
    `PIDC_ASSERT_NEXT(a_out_hold, state_reg == ST_DONE && stat.out_busy, state_reg == ST_DONE, "result register overwritten")
    `PIDC_ASSERT_NEXT(a_accept, state_reg == ST_IDLE && stat.in_valid, state_reg == ST_ERR, "accepted item not started")

endmodule

@@ test/pid_controller_step_checker.sv @@
// checker for the pid controller step unit: predicts each tick result and compares
module pid_controller_step_checker
    import pidc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    pidc_tick_if                 tick,
    pidc_result_if               result,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [DATA_W-1:0]    wr_data,
    output int                   failures,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [DATA_W-1:0] drive;
        logic signed [DATA_W-1:0] raw_drive;
        logic signed [DATA_W-1:0] error_value;
        logic signed [DATA_W-1:0] p_term;
        logic signed [DATA_W-1:0] i_term;
        logic signed [DATA_W-1:0] d_term;
        logic signed [DATA_W-1:0] ff_term;
        logic signed [DATA_W-1:0] d_unfiltered;
        logic                     hit_low;
        logic                     hit_high;
    } ctl_result_t;

    ctl_result_t tick_results_q[$];

    longint     kp, ki, kd, kff, int_lim, out_lim;
    deriv_src_t d_src;
    longint     tau;
    longint     integ_acc, last_err, last_meas, held_drive, d_filt;
    bit         primed;
    int         fail_cnt;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic longint rate(longint diff, longint dt);
        return sat32(diff * 1000000 / dt);
    endfunction

    function automatic ctl_result_t step_ctl(longint sp, longint meas, longint per, longint ffv,
                                             longint ext, bit ext_ok, bit ok, bit clr,
                                             bit restart, bit integ);
        ctl_result_t r;
        longint dt, err, raw, d, p, ff, sum, drv, q, inc, cand, cout;
        bit rst, lo, hi;
        r = '{default: 0};
        raw = 0;
        lo = 0;
        hi = 0;
        if (!ok)
        begin
            r.drive = held_drive;
            r.raw_drive = held_drive;
            return r;
        end
        dt = per;
        if (dt < 100) dt = 100;
        if (dt > 1000000) dt = 1000000;
        if (clr) integ_acc = 0;
        err = sat32(sp - meas);
        rst = restart || !primed;
        if (!rst)
        begin
            case (d_src)
                SRC_ERROR: raw = rate(err - last_err, dt);
                SRC_MEAS:  raw = rate(last_meas - meas, dt);
                SRC_EXT:   raw = ext_ok ? sat32(-ext) : rate(last_meas - meas, dt);
                default:   raw = 0;
            endcase
        end
        if (rst || tau == 0)
            d_filt = raw;
        else
            d_filt = d_filt + (raw - d_filt) * dt / (dt + tau);
        d = sat32(qmul(kd, d_filt));
        p = sat32(qmul(kp, err));
        ff = sat32(qmul(kff, ffv));
        if (integ && ki != 0)
        begin
            q = (ki * err) >>> 16;
            inc = (q / 1000000) * dt + (q % 1000000) * dt / 1000000;
            cand = clamp_sym(integ_acc + inc, int_lim);
            cout = p + cand + d + ff;
            if (!((cout > out_lim && err > 0) || (cout < -out_lim && err < 0)))
                integ_acc = cand;
        end
        sum = p + integ_acc + d + ff;
        if (sum < -out_lim)
        begin
            drv = -out_lim;
            lo = 1;
        end
        else if (sum > out_lim)
        begin
            drv = out_lim;
            hi = 1;
        end
        else
            drv = sum;
        r.drive = drv;
        r.raw_drive = sat32(sum);
        r.error_value = err;
        r.p_term = p;
        r.i_term = integ_acc;
        r.d_term = d;
        r.ff_term = ff;
        r.d_unfiltered = raw;
        r.hit_low = lo;
        r.hit_high = hi;
        last_err = err;
        last_meas = meas;
        held_drive = drv;
        primed = 1;
        return r;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        fail_cnt++;
    endtask

    task automatic compare(ctl_result_t w);
        if (result.drive !== w.drive) report("drive", result.drive, w.drive);
        if (result.raw_drive !== w.raw_drive) report("raw_drive", result.raw_drive, w.raw_drive);
        if (result.error_value !== w.error_value)
            report("error_value", result.error_value, w.error_value);
        if (result.p_term !== w.p_term) report("p_term", result.p_term, w.p_term);
        if (result.i_term !== w.i_term) report("i_term", result.i_term, w.i_term);
        if (result.d_term !== w.d_term) report("d_term", result.d_term, w.d_term);
        if (result.ff_term !== w.ff_term) report("ff_term", result.ff_term, w.ff_term);
        if (result.d_unfiltered !== w.d_unfiltered)
            report("d_unfiltered", result.d_unfiltered, w.d_unfiltered);
        if (result.hit_low !== w.hit_low) report("hit_low", result.hit_low, w.hit_low);
        if (result.hit_high !== w.hit_high) report("hit_high", result.hit_high, w.hit_high);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp = 0; ki = 0; kd = 0; kff = 0;
            d_src = SRC_OFF;
            tau = 0;
            int_lim = 64'h7FFFFFFF;
            out_lim = 64'h7FFFFFFF;
            integ_acc = 0; last_err = 0; last_meas = 0; held_drive = 0; d_filt = 0;
            primed = 0;
            fail_cnt = 0;
            tick_results_q.delete();
            failures <= 0;
            pending <= 0;
        end
        else
        begin
            if (wr_en)
            begin
                case (cfg_reg_t'(wr_index))
                    REG_GAIN_P:       kp = longint'(signed'(wr_data));
                    REG_GAIN_I:       ki = longint'(signed'(wr_data));
                    REG_GAIN_D:       kd = longint'(signed'(wr_data));
                    REG_GAIN_FF:      kff = longint'(signed'(wr_data));
                    REG_DERIV_SOURCE: d_src = deriv_src_t'(wr_data[1:0]);
                    REG_FILTER_TAU:   tau = longint'(wr_data[PERIOD_W-1:0]);
                    REG_INTEGRAL_LIMIT:
                    begin
                        int_lim = longint'(wr_data[LIMIT_W-1:0]);
                        integ_acc = clamp_sym(integ_acc, int_lim);
                    end
                    REG_OUTPUT_LIMIT: out_lim = longint'(wr_data[LIMIT_W-1:0]);
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (tick_results_q.size() == 0)
                begin
                    $display("unexpected result item at %0t", $realtime);
                    fail_cnt++;
                end
                else
                    compare(tick_results_q.pop_front());
            end
            if (tick.valid && tick.ready)
                tick_results_q.push_back(step_ctl(
                    longint'(tick.setpoint), longint'(tick.measurement),
                    longint'(tick.period_us), longint'(tick.ff_value),
                    longint'(tick.ext_rate), tick.ext_rate_valid, tick.sample_valid,
                    tick.clear_integral, tick.restart_derivative, tick.allow_integrate));
            failures <= fail_cnt;
            pending <= tick_results_q.size();
        end
    end
endmodule

@@ test/tb_pid_controller_step_unit.sv @@
// testbench top for the pid controller step unit: stimulus, receiver stalls and verdict
module tb_pid_controller_step_unit;
    import pidc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 clk;
    logic                 rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [DATA_W-1:0]    wr_data;
    int                   failures;
    int                   pending;
    int                   idle_cycles;
    int                   burst_left;
    int                   stall_mode;
    int                   stall_cnt;
    logic signed [DATA_W-1:0] meas_track;

    pidc_tick_if   tick_ch();
    pidc_result_if result_ch();

    pid_controller_step_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    pid_controller_step_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .failures (failures),
        .pending  (pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // receiver stalls in randomly picked modes: always ready, ready at random, or rarely ready
    always @(posedge clk)
    begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 256 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       result_ch.ready <= 1'b1;
            1:       result_ch.ready <= 1'($urandom_range(0, 1));
            default: result_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 5000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] rnd_q();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFFFFFF;
                    1: return 32'h80000000;
                    2: return 32'h0;
                    3: return 32'h1;
                    default: return 32'hFFFFFFFF;
                endcase
            end
            default: return $urandom_range(0, 1 << 23) - (1 << 22);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rnd_gain();
        if ($urandom_range(0, 7) == 0) return rnd_q();
        return $urandom_range(0, 1 << 19) - (1 << 18);
    endfunction

    function automatic logic [DATA_W-1:0] rnd_limit();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'h7FFFFFFF;
            2: return {1'b0, 31'($urandom)};
            default: return $urandom_range(0, 1 << 24);
        endcase
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [DATA_W-1:0] data);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_tick(logic [31:0] sp, logic [31:0] meas, logic [19:0] per,
                             logic [31:0] ffv, logic [31:0] ext, bit ext_ok, bit ok,
                             bit clr, bit restart, bit integ);
        tick_ch.valid <= 1'b1;
        tick_ch.setpoint <= sp;
        tick_ch.measurement <= meas;
        tick_ch.period_us <= per;
        tick_ch.ff_value <= ffv;
        tick_ch.ext_rate <= ext;
        tick_ch.ext_rate_valid <= ext_ok;
        tick_ch.sample_valid <= ok;
        tick_ch.clear_integral <= clr;
        tick_ch.restart_derivative <= restart;
        tick_ch.allow_integrate <= integ;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    task automatic random_config();
        write_reg(REG_GAIN_P, rnd_gain());
        write_reg(REG_GAIN_I, rnd_gain());
        write_reg(REG_GAIN_D, $urandom_range(0, 3) == 0 ? rnd_gain() : ($urandom_range(0, 1024)
                                                                      - 512));
        write_reg(REG_GAIN_FF, rnd_gain());
        write_reg(REG_DERIV_SOURCE, $urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0: write_reg(REG_FILTER_TAU, 0);
            1: write_reg(REG_FILTER_TAU, 1000000);
            default: write_reg(REG_FILTER_TAU, $urandom_range(0, 50000));
        endcase
        write_reg(REG_INTEGRAL_LIMIT, rnd_limit());
        write_reg(REG_OUTPUT_LIMIT, rnd_limit());
    endtask

    task automatic random_tick();
        logic [19:0] per;
        logic [31:0] sp;
        case ($urandom_range(0, 9))
            0: per = 0;
            1: per = 20'($urandom_range(0, 150));
            2: per = 20'($urandom);
            default: per = 20'($urandom_range(500, 20000));
        endcase
        if ($urandom_range(0, 9) == 0)
            meas_track = rnd_q();
        else
            meas_track = meas_track + $signed($urandom_range(0, 8192)) - 4096;
        sp = $urandom_range(0, 9) == 0 ? rnd_q() : meas_track + $urandom_range(0, 1 << 18)
                                                   - (1 << 17);
        send_tick(sp, meas_track, per, rnd_q(),
                  $urandom_range(0, 3) == 0 ? rnd_q() : $urandom_range(0, 1 << 22) - (1 << 21),
                  1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0,
                  $urandom_range(0, 19) == 0, $urandom_range(0, 19) == 0,
                  $urandom_range(0, 6) != 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        stall_cnt = 0;
        stall_mode = 0;
        idle_cycles = 0;
        burst_left = 0;
        meas_track = 0;
        result_ch.ready = 1'b0;
        tick_ch.valid = 1'b0;
        tick_ch.setpoint = '0;
        tick_ch.measurement = '0;
        tick_ch.period_us = '0;
        tick_ch.ff_value = '0;
        tick_ch.ext_rate = '0;
        tick_ch.ext_rate_valid = 1'b0;
        tick_ch.sample_valid = 1'b0;
        tick_ch.clear_integral = 1'b0;
        tick_ch.restart_derivative = 1'b0;
        tick_ch.allow_integrate = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every derivative source against the field extremes
        write_reg(REG_GAIN_P, 32'h00010000);
        write_reg(REG_GAIN_I, 32'h00020000);
        write_reg(REG_GAIN_D, 32'h00000100);
        write_reg(REG_GAIN_FF, 32'h00010000);
        write_reg(REG_INTEGRAL_LIMIT, 32'h00100000);
        write_reg(REG_OUTPUT_LIMIT, 32'h00200000);
        for (int s = 0; s < 4; s++)
        begin
            write_reg(REG_DERIV_SOURCE, s);
            write_reg(REG_FILTER_TAU, s[0] ? 32'd5000 : 32'd0);
            send_tick(32'h7FFFFFFF, 32'h80000000, 20'd0, 32'h7FFFFFFF, 32'h80000000,
                      1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
            send_tick(32'h80000000, 32'h7FFFFFFF, 20'd1, 32'h80000000, 32'h7FFFFFFF,
                      1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
            send_tick(32'h00010000, 32'h00000000, 20'hFFFFF, 32'h0, 32'h00050000,
                      1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
            send_tick(32'h00020000, 32'h00001000, 20'd1000, 32'h0, 32'h0,
                      1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
            send_tick(32'h00020000, 32'h00003000, 20'd1000000, 32'h1, 32'hFFFFFFFF,
                      1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
            send_tick(32'h00000000, 32'h00004000, 20'd100, 32'h0, 32'h0,
                      1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
            drain();
        end

        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph == 1)
            begin
                write_reg(REG_GAIN_P, 32'h7FFFFFFF);
                write_reg(REG_GAIN_I, 32'h80000000);
                write_reg(REG_GAIN_D, 32'h7FFFFFFF);
                write_reg(REG_GAIN_FF, 32'h80000000);
                write_reg(REG_DERIV_SOURCE, 32'(SRC_EXT));
                write_reg(REG_FILTER_TAU, 1000000);
                write_reg(REG_INTEGRAL_LIMIT, 32'h0);
                write_reg(REG_OUTPUT_LIMIT, 32'h0);
            end
            else
                random_config();
            for (int n = 0; n < 130; n++)
            begin
                random_tick();
                if (n == 60 && ph == 4)
                    drain();
            end
            drain();
        end

        tick_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
